/* sv/gac_pkg.sv */
// Shared types and constants for the greenhouse actuator control unit.
// Holds the transaction payload structs, register indexes and divider sizing.
// No dependencies.
package gac_pkg;

   // Field widths
   localparam int ECHO_W     = 15;
   localparam int SOIL_W     = 12;
   localparam int TEMP_W     = 12;
   localparam int HUM_W      = 10;
   localparam int PCT_W      = 7;
   localparam int THR_W      = 10;
   localparam int DIST_W     = 10;
   localparam int CAL_W      = 12;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 3;

   // Shared divider: quotient digits of DIV_DIGIT_W bits, one digit per cycle
   localparam int DIV_NUM_W   = 20;
   localparam int DIV_DEN_W   = 12;
   localparam int DIV_DIGIT_W = 2;
   localparam int DIV_CYCLES  = DIV_NUM_W / DIV_DIGIT_W;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

   // Echo time to cm: 0.034 cm/us out and back, i.e. *17/1000
   localparam int ECHO_CM_DIV = 1000;
   localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOIL_DRY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SOIL_WET = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_MIN = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_MAX = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_MAX  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_TANK_MT  = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_DRY  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_WET  = CSR_IDX_W'(7);

   typedef struct packed {
      logic [ECHO_W-1:0]        echo_us;
      logic [SOIL_W-1:0]        soil_raw;
      logic signed [TEMP_W-1:0] temp_tenths;
      logic [HUM_W-1:0]         hum_tenths;
      logic                     manual_mode;
      logic                     manual_pump;
      logic                     manual_fan;
      logic                     manual_heater;
   } req_type;

   typedef struct packed {
      logic             pump_on;
      logic             fan_on;
      logic             heater_on;
      logic [PCT_W-1:0] tank_level_pct;
      logic [PCT_W-1:0] soil_moisture_pct;
      logic             tank_has_water;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_res_type;

   function automatic logic [DIV_NUM_W-1:0] times17(input logic [DIV_NUM_W-1:0] x);
      return (x << 4) + x;
   endfunction

   function automatic logic [DIV_NUM_W-1:0] times100(input logic [DIV_NUM_W-1:0] x);
      return (x << 6) + (x << 5) + (x << 2);
   endfunction

endpackage

/* sv/gac_div.sv */
// Restoring unsigned divider, DIV_DIGIT_W quotient bits per cycle.
// The dividend shifts out of the top of the quotient register as quotient bits enter below.
// Depends on gac_pkg.
module gac_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gac_pkg::div_cmd_type cmd,
   output gac_pkg::div_res_type res
);
   import gac_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int i = 0; i < DIV_DIGIT_W; i++) begin
         trial  = {rem_in, quo_in[DIV_NUM_W-1]};
         quo_in = {quo_in[DIV_NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DIV_DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= '0;
         quo_ff <= cmd.dividend;
         den_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Quotient holds after done until the next start
   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

/* sv/greenhouse_actuator_control_unit.sv */
// Greenhouse actuator control unit: one result transaction per control tick.
// Depends on gac_pkg and gac_div.
//
// One request transaction is taken at a time; the next is taken only once the result
// of the previous one has been loaded into the output register. The single shared
// divider sets this pace. It produces two quotient bits per cycle and runs three
// 20-bit divisions in turn: echo time to distance, distance to tank level, and soil
// sample to moisture. Each division registers its operands, loads the divider, iterates
// and then takes the quotient. The result sits in an output register, so the next
// request is taken while it waits to be read. A result that waits under rsp_stall
// holds back the following result, and after it the next request, only if it is still
// stalled when that following result is ready.
module greenhouse_actuator_control_unit #(
   parameter int TANK_FULL_CM = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gac_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gac_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [gac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gac_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gac_pkg::*;

   localparam logic [DIST_W-1:0] FULL_CM = DIST_W'(TANK_FULL_CM);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIST  = 7'b0000010,
      ST_TPREP = 7'b0000100,
      ST_TANK  = 7'b0001000,
      ST_SPREP = 7'b0010000,
      ST_SOIL  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic [PCT_W-1:0] soil_dry_ff, soil_wet_ff;
   logic [THR_W-1:0] temp_min_ff, temp_max_ff, hum_max_ff;
   logic [DIST_W-1:0] tank_empty_ff;
   logic [CAL_W-1:0] cal_dry_ff, cal_wet_ff;

   // Per-transaction working registers
   logic                 echo_zero_ff;
   logic [SOIL_W-1:0]    soil_cl_ff;
   logic                 manual_ff, m_pump_ff, fan_ff, heat_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic                 water_ff;
   logic                 tank_ok_ff, soil_ok_ff;
   logic [PCT_W-1:0]     level_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic                 div_start_ff;
   logic                 pump_latch_ff, pump_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   div_cmd_type div_cmd;
   div_res_type div_res;

   logic                  accept;
   logic                  out_free;
   logic [SOIL_W-1:0]     soil_cl;
   logic signed [TEMP_W:0] temp_ext, temp_max_ext, temp_min_ext;
   logic [DIST_W-1:0]     dist_raw, dist_cl;
   logic [PCT_W-1:0]      moist;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Soil clamp: below the wet bound gives the wet bound, else lower to the dry bound
   assign soil_cl = (req_data.soil_raw < cal_wet_ff) ? cal_wet_ff :
                    (req_data.soil_raw > cal_dry_ff) ? cal_dry_ff : req_data.soil_raw;

   assign temp_ext     = {req_data.temp_tenths[TEMP_W-1], req_data.temp_tenths};
   assign temp_max_ext = $signed({{(TEMP_W + 1 - THR_W){1'b0}}, temp_max_ff});
   assign temp_min_ext = $signed({{(TEMP_W + 1 - THR_W){1'b0}}, temp_min_ff});

   // Distance clamp: below full gives full, else lower to empty
   assign dist_raw = echo_zero_ff ? tank_empty_ff : div_res.quotient[DIST_W-1:0];
   assign dist_cl  = (dist_raw < FULL_CM) ? FULL_CM :
                     (dist_raw > tank_empty_ff) ? tank_empty_ff : dist_raw;

   assign moist = soil_ok_ff ? div_res.quotient[PCT_W-1:0] : '0;

   always_comb begin
      pump_in = pump_latch_ff;
      if (manual_ff) begin
         pump_in = m_pump_ff;
      end else if (moist < soil_dry_ff && water_ff) begin
         pump_in = 1'b1;
      end else if (moist > soil_wet_ff || !water_ff) begin
         pump_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIST;
         end
         ST_DIST: begin
            if (div_res.done) state_in = ST_TPREP;
         end
         ST_TPREP: begin
            state_in = ST_TANK;
         end
         ST_TANK: begin
            if (div_res.done) state_in = ST_SPREP;
         end
         ST_SPREP: begin
            state_in = ST_SOIL;
         end
         ST_SOIL: begin
            if (div_res.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         div_start_ff  <= 1'b0;
         pump_latch_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         soil_dry_ff   <= PCT_W'(40);
         soil_wet_ff   <= PCT_W'(70);
         temp_min_ff   <= THR_W'(200);
         temp_max_ff   <= THR_W'(300);
         hum_max_ff    <= THR_W'(750);
         tank_empty_ff <= DIST_W'(25);
         cal_dry_ff    <= CAL_W'(4095);
         cal_wet_ff    <= CAL_W'(1670);
      end else begin
         state_ff     <= state_in;
         div_start_ff <= accept || (state_ff == ST_TPREP) || (state_ff == ST_SPREP);
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff  <= 1'b1;
            pump_latch_ff <= pump_in;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SOIL_DRY: soil_dry_ff   <= csr_wdata[PCT_W-1:0];
               CSR_SOIL_WET: soil_wet_ff   <= csr_wdata[PCT_W-1:0];
               CSR_TEMP_MIN: temp_min_ff   <= csr_wdata[THR_W-1:0];
               CSR_TEMP_MAX: temp_max_ff   <= csr_wdata[THR_W-1:0];
               CSR_HUM_MAX:  hum_max_ff    <= csr_wdata[THR_W-1:0];
               CSR_TANK_MT:  tank_empty_ff <= csr_wdata[DIST_W-1:0];
               CSR_CAL_DRY:  cal_dry_ff    <= csr_wdata[CAL_W-1:0];
               CSR_CAL_WET:  cal_wet_ff    <= csr_wdata[CAL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         echo_zero_ff <= (req_data.echo_us == '0);
         soil_cl_ff   <= soil_cl;
         manual_ff    <= req_data.manual_mode;
         m_pump_ff    <= req_data.manual_pump;
         if (req_data.manual_mode) begin
            fan_ff  <= req_data.manual_fan;
            heat_ff <= req_data.manual_heater;
         end else begin
            fan_ff  <= (temp_ext > temp_max_ext) || (req_data.hum_tenths > hum_max_ff);
            heat_ff <= (temp_ext < temp_min_ext);
         end
         num_ff <= times17(DIV_NUM_W'(req_data.echo_us));
         den_ff <= DIV_DEN_W'(ECHO_CM_DIV);
      end
      if (state_ff == ST_DIST && div_res.done) begin
         dist_ff  <= dist_cl;
         water_ff <= (dist_cl < tank_empty_ff);
      end
      if (state_ff == ST_TPREP) begin
         // level = |empty - dist| * 100 / |empty - full|; zero when the span is empty
         tank_ok_ff <= (tank_empty_ff != FULL_CM);
         if (tank_empty_ff > FULL_CM) begin
            num_ff <= times100(DIV_NUM_W'(tank_empty_ff - dist_ff));
            den_ff <= DIV_DEN_W'(tank_empty_ff - FULL_CM);
         end else begin
            num_ff <= times100(DIV_NUM_W'(dist_ff - tank_empty_ff));
            den_ff <= DIV_DEN_W'(FULL_CM - tank_empty_ff);
         end
      end
      if (state_ff == ST_TANK && div_res.done) begin
         level_ff <= tank_ok_ff ? div_res.quotient[PCT_W-1:0] : '0;
      end
      if (state_ff == ST_SPREP) begin
         // moisture = |dry - soil| * 100 / |dry - wet|; zero when the points are equal
         soil_ok_ff <= (cal_wet_ff != cal_dry_ff);
         if (cal_wet_ff < cal_dry_ff) begin
            num_ff <= times100(DIV_NUM_W'(cal_dry_ff - soil_cl_ff));
            den_ff <= DIV_DEN_W'(cal_dry_ff - cal_wet_ff);
         end else begin
            num_ff <= times100(DIV_NUM_W'(soil_cl_ff - cal_dry_ff));
            den_ff <= DIV_DEN_W'(cal_wet_ff - cal_dry_ff);
         end
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff.pump_on           <= pump_in;
         rsp_data_ff.fan_on            <= fan_ff;
         rsp_data_ff.heater_on         <= heat_ff;
         rsp_data_ff.tank_level_pct    <= level_ff;
         rsp_data_ff.soil_moisture_pct <= moist;
         rsp_data_ff.tank_has_water    <= water_ff;
      end
   end

   assign div_cmd.start    = div_start_ff;
   assign div_cmd.dividend = num_ff;
   assign div_cmd.divisor  = den_ff;

   gac_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DIST)
      else $error("accepted transaction did not start the distance division");

   a_div_done_busy: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIST || state_ff == ST_TANK || state_ff == ST_SOIL))
      else $error("divider finished outside a division state");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.tank_level_pct <= PCT_MAX && rsp_data.soil_moisture_pct <= PCT_MAX))
      else $error("percent output above 100");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

endmodule
